### rtl/core/ppos_pkg.sv
`timescale 1ns / 1ps

package ppos_pkg;

  // Fixed field widths of the stream payloads
  localparam int PATTERN_W = 32;
  localparam int INDEX_W   = 6;
  localparam int IN_DATA_W = 32;
  localparam int OUT_DATA_W = 8;

  // Commands from the controller to the sort chain
  typedef struct packed {
    logic insert;  // place the incoming pattern into the chain
    logic shift;   // drop the head entry and advance the chain
  } cmd_t;

  // Status from the sort chain to the controller
  typedef struct packed {
    logic full;      // chain holds its full capacity
    logic last_out;  // head entry is the final one of the run
  } status_t;

endpackage

### rtl/core/ppos_ctrl.sv
`timescale 1ns / 1ps

module ppos_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_last,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output ppos_pkg::cmd_t   cmd,
  input  ppos_pkg::status_t status
);

  localparam logic ST_LOAD = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic state;
  logic state_next;
  logic in_take;
  logic out_take;

  // Handshakes follow the phase
  assign in_ready  = (state == ST_LOAD);
  assign out_valid = (state == ST_EMIT);
  assign in_take   = in_valid & in_ready;
  assign out_take  = out_valid & out_ready;

  // Insert while there is room, advance on each delivered index
  assign cmd.insert = in_take & ~status.full;
  assign cmd.shift  = out_take;

  // Phase sequencing
  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD: begin
        if (in_take && in_last) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_take && status.last_out) begin
          state_next = ST_LOAD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

endmodule

### rtl/core/ppos_chain.sv
`timescale 1ns / 1ps

module ppos_chain #(
  parameter int MAX_PATTERNS = 64,
  parameter int PATTERN_BITS = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [ppos_pkg::PATTERN_W-1:0]     pattern,
  input  ppos_pkg::cmd_t                     cmd,
  output ppos_pkg::status_t                  status,
  output logic [ppos_pkg::INDEX_W-1:0]       head_index
);

  localparam int TAG_W = $clog2(MAX_PATTERNS);
  localparam int CNT_W = $clog2(MAX_PATTERNS + 1);
  localparam int POP_W = $clog2(PATTERN_BITS + 1);
  localparam int KEY_W = POP_W + PATTERN_BITS + TAG_W;
  localparam int EXT_W = (PATTERN_BITS > ppos_pkg::PATTERN_W) ? PATTERN_BITS
                                                              : ppos_pkg::PATTERN_W;

  logic [KEY_W-1:0]        slot_key [MAX_PATTERNS];
  logic [KEY_W-1:0]        slot_key_next [MAX_PATTERNS];
  logic [CNT_W-1:0]        count;
  logic [EXT_W-1:0]        pat_ext;
  logic [PATTERN_BITS-1:0] pat_m;
  logic [PATTERN_BITS-1:0] pat_rev;
  logic [POP_W-1:0]        pop;
  logic [KEY_W-1:0]        new_key;
  logic [MAX_PATTERNS-1:0] stays;

  // Mask the pattern to the configured width
  assign pat_ext = EXT_W'(pattern);
  assign pat_m   = pat_ext[PATTERN_BITS-1:0];

  // Build the key: popcount up, bit-reversed value down, arrival tag up
  always_comb begin
    pop = '0;
    for (int b = 0; b < PATTERN_BITS; b++) begin
      pop        = pop + POP_W'(pat_m[b]);
      pat_rev[PATTERN_BITS-1-b] = pat_m[b];
    end
  end

  assign new_key = {pop, ~pat_rev, count[TAG_W-1:0]};

  // Entries that order ahead of the new key keep their slot
  always_comb begin
    for (int i = 0; i < MAX_PATTERNS; i++) begin
      stays[i] = (CNT_W'(i) < count) && (slot_key[i] < new_key);
    end
  end

  // Insert shifts the tail up by one; shift moves every entry toward the head
  always_comb begin
    for (int i = 0; i < MAX_PATTERNS; i++) begin
      slot_key_next[i] = slot_key[i];
      if (cmd.insert) begin
        if (!stays[i]) begin
          if (i == 0) begin
            slot_key_next[i] = new_key;
          end else if (stays[i-1]) begin
            slot_key_next[i] = new_key;
          end else begin
            slot_key_next[i] = slot_key[i-1];
          end
        end
      end else if (cmd.shift) begin
        if (i < MAX_PATTERNS - 1) begin
          slot_key_next[i] = slot_key[i+1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_PATTERNS; i++) begin
      slot_key[i] <= slot_key_next[i];
    end
  end

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.insert) begin
      count <= count + CNT_W'(1);
    end else if (cmd.shift) begin
      count <= count - CNT_W'(1);
    end
  end

  assign status.full     = (count == CNT_W'(MAX_PATTERNS));
  assign status.last_out = (count == CNT_W'(1));
  assign head_index      = ppos_pkg::INDEX_W'(slot_key[0][TAG_W-1:0]);

endmodule

### rtl/core/pattern_popcount_order_sort_unit.sv
`timescale 1ns / 1ps
// Load phase: one pattern request per cycle, stored in sorted place if not full.
// After the request with tlast, the first index is offered on the next cycle and
// indices stream out one per cycle while m_axis_tready is high; the sort chain's
// shift sets that rate. Input is not taken while a run is being emitted.
// Synchronous active-high rst empties the chain and returns to the load phase.
module pattern_popcount_order_sort_unit #(
  parameter int MAX_PATTERNS = 64,
  parameter int PATTERN_BITS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [ppos_pkg::IN_DATA_W-1:0]       s_axis_tdata,  // [31:0] pattern
  input  logic                                 s_axis_tlast,  // is_last
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [ppos_pkg::OUT_DATA_W-1:0]      m_axis_tdata,  // [5:0] order_index
  output logic                                 m_axis_tlast   // end_of_run
);

  ppos_pkg::cmd_t                cmd;
  ppos_pkg::status_t             status;
  logic [ppos_pkg::INDEX_W-1:0]  head_index;

  ppos_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_last   (s_axis_tlast),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd),
    .status    (status)
  );

  ppos_chain #(
    .MAX_PATTERNS (MAX_PATTERNS),
    .PATTERN_BITS (PATTERN_BITS)
  ) u_chain (
    .clk        (clk),
    .rst        (rst),
    .pattern    (s_axis_tdata[ppos_pkg::PATTERN_W-1:0]),
    .cmd        (cmd),
    .status     (status),
    .head_index (head_index)
  );

  // Pad the index to a whole byte
  assign m_axis_tdata = ppos_pkg::OUT_DATA_W'(head_index);
  assign m_axis_tlast = status.last_out;

endmodule

### verif/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int MAX_PATTERNS = 64;
  localparam int PATTERN_BITS = 32;
  localparam int TARGET_ITEMS = 450;
  localparam int SHOWN_MISMATCHES = 10;
  localparam int DRAIN_CYCLES = 20;

  typedef struct {
    logic [ppos_pkg::PATTERN_W-1:0] pattern;
    logic                           is_last;
  } pattern_req_t;

  typedef struct {
    logic [ppos_pkg::INDEX_W-1:0] order_index;
    logic                         end_of_run;
  } order_result_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [ppos_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;   // [31:0] pattern
  logic                            s_axis_tlast = 1'b0; // is_last
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [ppos_pkg::OUT_DATA_W-1:0] m_axis_tdata;        // [5:0] order_index
  logic                            m_axis_tlast;        // end_of_run

  pattern_req_t                   pending_requests[$];
  pattern_req_t                   next_request;
  logic [ppos_pkg::PATTERN_W-1:0] held_patterns[$];
  order_result_t                  expected_order[$];
  order_result_t                  expected_head;
  int                             total_items;
  int                             accepted_items = 0;
  int                             error_count = 0;

  pattern_popcount_order_sort_unit #(
    .MAX_PATTERNS(MAX_PATTERNS),
    .PATTERN_BITS(PATTERN_BITS)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always #10 clk = ~clk;

  // Idle rates by thirds of the run: light sender gaps, then heavy, then none
  function automatic int send_idle_pct();
    if (accepted_items * 3 < total_items) return 7;
    if (accepted_items * 3 < total_items * 2) return 54;
    return 0;
  endfunction

  function automatic int recv_idle_pct();
    if (accepted_items * 3 < total_items) return 54;
    if (accepted_items * 3 < total_items * 2) return 7;
    return 0;
  endfunction

  // Fewer ones first; on equal count the pattern set at the lowest differing bit wins
  function automatic bit ranks_first(logic [ppos_pkg::PATTERN_W-1:0] x, int tag_x,
                                     logic [ppos_pkg::PATTERN_W-1:0] y, int tag_y);
    logic [ppos_pkg::PATTERN_W-1:0] diff;
    diff = x ^ y;
    if ($countones(x) != $countones(y)) return $countones(x) < $countones(y);
    if (diff != '0) return (x & (diff & (~diff + 1'b1))) != '0;
    return tag_x < tag_y;
  endfunction

  // Hold the pattern while there is room; on the last request sort and queue the run
  task automatic predict_request(logic [ppos_pkg::PATTERN_W-1:0] pattern, logic is_last);
    int            rank[$];
    int            pos;
    order_result_t res;
    if (held_patterns.size() < MAX_PATTERNS) held_patterns.push_back(pattern);
    if (!is_last) return;
    for (int i = 0; i < held_patterns.size(); i++) begin
      pos = rank.size();
      while (pos > 0 && ranks_first(held_patterns[i], i,
                                    held_patterns[rank[pos-1]], rank[pos-1]))
        pos--;
      rank.insert(pos, i);
    end
    foreach (rank[k]) begin
      res.order_index = rank[k][ppos_pkg::INDEX_W-1:0];
      res.end_of_run  = (k == rank.size() - 1);
      expected_order.push_back(res);
    end
    held_patterns.delete();
  endtask

  task automatic note_mismatch(string what, order_result_t want, order_result_t got);
    error_count++;
    if (error_count <= SHOWN_MISMATCHES)
      $display("%0t: %s: expected index %0d last %0b, got index %0d last %0b", $realtime,
               what, want.order_index, want.end_of_run, got.order_index, got.end_of_run);
  endtask

  task automatic add_set(logic [ppos_pkg::PATTERN_W-1:0] pats[$]);
    pattern_req_t req;
    foreach (pats[i]) begin
      req.pattern = pats[i];
      req.is_last = (i == pats.size() - 1);
      pending_requests.push_back(req);
    end
  endtask

  // Mix dense, sparse and repeated values so popcount ties are common
  function automatic logic [ppos_pkg::PATTERN_W-1:0] random_pattern(
      logic [ppos_pkg::PATTERN_W-1:0] prior[$]);
    logic [ppos_pkg::PATTERN_W-1:0] pat;
    int                             kind;
    kind = $urandom_range(0, 9);
    pat = '0;
    if (kind < 3) begin
      pat = $urandom();
    end else if (kind < 7) begin
      repeat ($urandom_range(0, 4)) pat[$urandom_range(0, ppos_pkg::PATTERN_W-1)] = 1'b1;
    end else if (kind < 8) begin
      pat = ~'0;
      repeat ($urandom_range(0, 3)) pat[$urandom_range(0, ppos_pkg::PATTERN_W-1)] = 1'b0;
    end else if (prior.size() != 0) begin
      pat = prior[$urandom_range(0, prior.size() - 1)];
    end else begin
      pat = $urandom();
    end
    return pat;
  endfunction

  task automatic build_random_sets();
    logic [ppos_pkg::PATTERN_W-1:0] pats[$];
    int                             set_size;
    // Exactly full, then overfull with the closing request among those dropped
    repeat (MAX_PATTERNS) pats.push_back(random_pattern(pats));
    add_set(pats);
    pats.delete();
    repeat (MAX_PATTERNS + 3) pats.push_back(random_pattern(pats));
    add_set(pats);
    while (pending_requests.size() < TARGET_ITEMS) begin
      pats.delete();
      set_size = ($urandom_range(0, 11) == 0) ? $urandom_range(20, MAX_PATTERNS + 4)
                                              : $urandom_range(1, 10);
      // Trim the final set to the item budget
      if (set_size > TARGET_ITEMS - pending_requests.size())
        set_size = TARGET_ITEMS - pending_requests.size();
      repeat (set_size) pats.push_back(random_pattern(pats));
      add_set(pats);
    end
  endtask

  // Driver: advance to the next request once the current one is taken
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tlast  <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_request(s_axis_tdata[ppos_pkg::PATTERN_W-1:0], s_axis_tlast);
        accepted_items <= accepted_items + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct()) begin
          next_request = pending_requests.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= next_request.pattern;
          s_axis_tlast  <= next_request.is_last;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each taken index with the oldest expected one
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        order_result_t got;
        got.order_index = m_axis_tdata[ppos_pkg::INDEX_W-1:0];
        got.end_of_run  = m_axis_tlast;
        if (expected_order.size() == 0) begin
          note_mismatch("unexpected index", '{default: 'x}, got);
        end else begin
          expected_head = expected_order.pop_front();
          if (got.order_index !== expected_head.order_index ||
              got.end_of_run !== expected_head.end_of_run)
            note_mismatch("index mismatch", expected_head, got);
        end
      end
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct());
    end
  end

  initial begin
    // Extremes, single bits, duplicates and one-entry set
    add_set('{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000,
              32'h0000_0002, 32'h0000_0003, 32'h0000_0000, 32'h0000_0001});
    add_set('{32'hA5A5_A5A5});
    // Equal popcounts ordered by lowest differing bit
    add_set('{32'h0000_000F, 32'h0000_00F0, 32'h0000_0033, 32'h0000_00CC,
              32'h0000_0055, 32'h0000_00AA, 32'h0000_000F});
    add_set('{32'h8000_0001, 32'h4000_0002, 32'hC000_0000, 32'h0000_0003});
    build_random_sets();
    total_items = pending_requests.size();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (pending_requests.size() != 0 || s_axis_tvalid) @(posedge clk);
    while (expected_order.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0 && expected_order.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #2ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
